// ----- design/tilt_pkg.sv -----
// ----------------------------------------------------------------------------
// tilt_pkg: shared types and constants for the tilt angle block
// Angle limits, CORDIC arctangent table (1/65536 degree), widths.
// ----------------------------------------------------------------------------
package tilt_pkg;

	localparam int AxisW       = 16;
	localparam int AngleW      = 15;
	localparam int WeightW     = 16;
	localparam int SqW         = 33;	// a^2 + b^2 < 2^31 + 2^31
	localparam int RootW       = 17;	// floor sqrt of SqW bits
	localparam int CordW       = 28;	// datapath of x/y rotation
	localparam int ZW          = 24;	// angle accumulator
	localparam int StepsDef    = 16;
	localparam int StepsMax    = 24;
	localparam int AngleLimit  = 11520;
	localparam logic [WeightW-1:0] WeightReset = 16'd3932;

	typedef logic signed [AngleW-1:0] angle_t;

	// lane control from the top-level sequencer
	typedef struct packed {
		logic start;
		logic step;
	} lane_ctl_t;

	// arctangent of 2^-i in 1/65536 degree, rounded
	function automatic logic [22:0] atan_lut(input logic [4:0] i);
		logic [22:0] v;
		begin
			case (i)
				5'd0:  v = 23'd2949120;
				5'd1:  v = 23'd1740967;
				5'd2:  v = 23'd919879;
				5'd3:  v = 23'd466945;
				5'd4:  v = 23'd234379;
				5'd5:  v = 23'd117304;
				5'd6:  v = 23'd58666;
				5'd7:  v = 23'd29335;
				5'd8:  v = 23'd14668;
				5'd9:  v = 23'd7334;
				5'd10: v = 23'd3667;
				5'd11: v = 23'd1833;
				5'd12: v = 23'd917;
				5'd13: v = 23'd458;
				5'd14: v = 23'd229;
				5'd15: v = 23'd115;
				5'd16: v = 23'd57;
				5'd17: v = 23'd29;
				5'd18: v = 23'd14;
				5'd19: v = 23'd7;
				5'd20: v = 23'd4;
				5'd21: v = 23'd2;
				5'd22: v = 23'd1;
				default: v = 23'd0;
			endcase
			return v;
		end
	endfunction

endpackage

// ----- design/tilt_if.sv -----
// ----------------------------------------------------------------------------
// tilt_in_if / tilt_out_if: valid/ready channels of the tilt angle block
// One word is moved when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface tilt_in_if;
	logic                     valid;
	logic                     ready;
	logic signed [15:0]       accel_x;
	logic signed [15:0]       accel_y;
	logic signed [15:0]       accel_z;
	modport source (output valid, accel_x, accel_y, accel_z, input ready);
	modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface tilt_out_if;
	logic                     valid;
	logic                     ready;
	logic signed [14:0]       roll_angle;
	logic signed [14:0]       pitch_angle;
	logic signed [14:0]       roll_smoothed;
	logic signed [14:0]       pitch_smoothed;
	modport source (output valid, roll_angle, pitch_angle, roll_smoothed,
		pitch_smoothed, input ready);
	modport sink   (input valid, roll_angle, pitch_angle, roll_smoothed,
		pitch_smoothed, output ready);
endinterface

// ----- design/tilt_lane.sv -----
// ----------------------------------------------------------------------------
// tilt_lane: one angle lane
// Bit-serial integer square root (one result bit per cycle) followed by an
// iterative CORDIC vectoring loop (one rotation per cycle). Gives
// atan(num / sqrt(a^2 + b^2)) in 1/128 degree, saturated.
// ----------------------------------------------------------------------------
module tilt_lane #(
	parameter int CordicSteps = tilt_pkg::StepsDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tilt_pkg::lane_ctl_t       ctl,
	input  logic signed [16:0]        num,
	input  logic signed [15:0]        op_a,
	input  logic signed [15:0]        op_b,
	output logic                      done,
	output tilt_pkg::angle_t          angle
);
	import tilt_pkg::*;

	localparam int SqrtIters = RootW;	// one root bit per cycle
	localparam int CntW      = 6;

	typedef enum logic [1:0] {S_IDLE, S_SQRT, S_ROT, S_DONE} lstate_t;

	lstate_t                  state_q;
	logic [CntW-1:0]          cnt_q;
	logic [SqW-1:0]           rem_q;
	logic [RootW-1:0]         root_q;
	logic signed [16:0]       num_q;
	logic signed [CordW-1:0]  x_q, y_q;
	logic signed [ZW-1:0]     z_q;
	angle_t                   angle_q;

	// squares of the two operands
	logic [31:0] sq_a, sq_b;
	assign sq_a = 32'($signed(op_a) * $signed(op_a));
	assign sq_b = 32'($signed(op_b) * $signed(op_b));

	// restoring square root: trial = (root << 2 | 1) against remainder top
	logic [4:0]        sq_sh;
	logic [SqW-1:0]    win;
	logic [RootW+1:0]  trial;
	logic              take;
	assign sq_sh = 5'(SqrtIters - 1) - 5'(cnt_q);

	// CORDIC step
	logic [4:0]               rot_i;
	logic signed [CordW-1:0]  xs, ys;
	logic signed [ZW-1:0]     at;
	logic signed [ZW-1:0]     zr;
	logic signed [ZW-10:0]    zq;

	always_comb begin
		win   = rem_q >> {sq_sh, 1'b0};
		trial = {root_q, 1'b0, 1'b1};
		take  = ({{(SqW-RootW-2){1'b0}}, trial} <= win);
		rot_i = 5'(cnt_q);
		xs    = x_q >>> rot_i;
		ys    = y_q >>> rot_i;
		at    = ZW'(atan_lut(rot_i));
		zr    = z_q + ZW'(256);
		zq    = zr[ZW-1:9];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ctl.start) begin
						rem_q   <= SqW'(sq_a) + SqW'(sq_b);
						root_q  <= '0;
						num_q   <= num;
						cnt_q   <= '0;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (take) begin
						rem_q  <= rem_q - ({{(SqW-RootW-2){1'b0}}, trial} << {sq_sh, 1'b0});
						root_q <= {root_q[RootW-2:0], 1'b1};
					end else begin
						root_q <= {root_q[RootW-2:0], 1'b0};
					end
					if (cnt_q == CntW'(SqrtIters - 1)) begin
						cnt_q   <= '0;
						state_q <= S_ROT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ROT: begin
					if (cnt_q == '0) begin
						// load the rotation vector once the root is final
						x_q <= CordW'({1'b0, root_q, 8'd0});
						y_q <= CordW'($signed({num_q, 8'd0}));
						z_q <= '0;
						cnt_q <= '0;
						state_q <= S_DONE;
					end
				end
				default: begin
					if (cnt_q == CntW'(CordicSteps)) begin
						// pack result; a zero root means a vertical vector
						if (num_q == '0) angle_q <= '0;
						else if (root_q == '0) angle_q <= num_q[16] ?
							angle_t'(-AngleLimit) : angle_t'(AngleLimit);
						else if (zq > (ZW-9)'(AngleLimit)) angle_q <= angle_t'(AngleLimit);
						else if (zq < -(ZW-9)'(AngleLimit)) angle_q <= angle_t'(-AngleLimit);
						else angle_q <= angle_t'(zq);
						state_q <= S_IDLE;
					end else begin
						if (!y_q[CordW-1]) begin
							x_q <= x_q + ys;
							y_q <= y_q - xs;
							z_q <= z_q + at;
						end else begin
							x_q <= x_q - ys;
							y_q <= y_q + xs;
							z_q <= z_q - at;
						end
						cnt_q <= cnt_q + 1'b1;
					end
				end
			endcase
		end
	end

	// done pulses on the cycle the angle register loads
	assign done  = (state_q == S_DONE) && (cnt_q == CntW'(CordicSteps));
	assign angle = angle_q;

	logic unused_step;
	assign unused_step = ctl.step;
endmodule

// ----- design/tilt_filt.sv -----
// ----------------------------------------------------------------------------
// tilt_filt: merging stage, two first-order low-pass filters
// acc += round(weight * (angle - acc) / 65536), saturated. Each multiply is
// registered, then the add; roll and pitch take turns.
// ----------------------------------------------------------------------------
module tilt_filt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [15:0]          weight,
	input  tilt_pkg::angle_t     roll_in,
	input  tilt_pkg::angle_t     pitch_in,
	output logic                 done,
	output tilt_pkg::angle_t     roll_acc,
	output tilt_pkg::angle_t     pitch_acc
);
	import tilt_pkg::*;

	typedef enum logic [2:0] {F_IDLE, F_MR, F_AR, F_MP, F_AP} fstate_t;

	fstate_t              state_q;
	angle_t               roll_q, pitch_q;
	logic signed [33:0]   prod_s1;

	logic signed [16:0] diff;
	logic signed [33:0] rnd;
	logic signed [18:0] sum;
	angle_t             acc_sel, ang_sel, sat;

	always_comb begin
		acc_sel = (state_q == F_MR || state_q == F_AR) ? roll_q : pitch_q;
		ang_sel = (state_q == F_MR || state_q == F_AR) ? roll_in : pitch_in;
		diff    = 17'(ang_sel) - 17'(acc_sel);
		rnd     = prod_s1 + 34'sd32768;
		sum     = 19'(acc_sel) + 19'(rnd >>> 16);
		if (sum > 19'sd11520) sat = angle_t'(AngleLimit);
		else if (sum < -19'sd11520) sat = angle_t'(-AngleLimit);
		else sat = angle_t'(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			roll_q  <= '0;
			pitch_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: if (start) state_q <= F_MR;
				F_MR: begin
					prod_s1 <= $signed({1'b0, weight}) * diff;
					state_q <= F_AR;
				end
				F_AR: begin
					roll_q  <= sat;
					state_q <= F_MP;
				end
				F_MP: begin
					prod_s1 <= $signed({1'b0, weight}) * diff;
					state_q <= F_AP;
				end
				default: begin
					pitch_q <= sat;
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	assign done      = (state_q == F_AP);
	assign roll_acc  = roll_q;
	assign pitch_acc = pitch_q;
endmodule

// ----- design/accel_tilt_angles_filtered.sv -----
// ----------------------------------------------------------------------------
// accel_tilt_angles_filtered: roll/pitch from a 3-axis sample, low-pass
// Two lanes (roll, pitch) each run sqrt + CORDIC; a filter stage merges.
//
//  channel  dir  word
//  in_ch    in   accel_x, accel_y, accel_z (s16)
//  out_ch   out  roll/pitch angle, roll/pitch smoothed (s15, 1/128 deg)
//  filter_weight_we/_wdata  cfg  Q16 weight, reset 3932
//
// An item runs the square root, the vector load, CordicSteps rotations (16 by
// default) and the pack in each lane, then the handoff, the filter's multiply
// and add for roll and then for pitch, and the output load.
// One item at a time; a new word is taken once the previous result has been
// moved into the output register. Output stalls hold the result.
// Reset clears both filter states and restores the default weight.
// ----------------------------------------------------------------------------
module accel_tilt_angles_filtered #(
	parameter int CordicSteps = tilt_pkg::StepsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               filter_weight_we,
	input  logic [15:0]        filter_weight_wdata,
	tilt_in_if.sink            in_ch,
	tilt_out_if.source         out_ch
);
	import tilt_pkg::*;

	typedef enum logic [1:0] {T_IDLE, T_LANE, T_FILT, T_OUT} tstate_t;

	tstate_t          state_q;
	logic [15:0]      weight_q;
	logic             lr_done_q, lp_done_q;
	lane_ctl_t        ctl;
	logic             r_done, p_done, f_done;
	angle_t           r_ang, p_ang, r_acc, p_acc;
	logic signed [16:0] r_num, p_num;
	logic             out_load;

	assign in_ch.ready = (state_q == T_IDLE);
	assign ctl.start   = in_ch.valid && in_ch.ready;
	assign ctl.step    = 1'b0;
	assign r_num       = 17'(in_ch.accel_y);
	assign p_num       = -17'(in_ch.accel_x);
	assign out_load    = (state_q == T_OUT) && (!out_ch.valid || out_ch.ready);

	tilt_lane #(.CordicSteps(CordicSteps)) u_roll (
		.clk, .arst_n, .ctl, .num(r_num), .op_a(in_ch.accel_x),
		.op_b(in_ch.accel_z), .done(r_done), .angle(r_ang));

	tilt_lane #(.CordicSteps(CordicSteps)) u_pitch (
		.clk, .arst_n, .ctl, .num(p_num), .op_a(in_ch.accel_y),
		.op_b(in_ch.accel_z), .done(p_done), .angle(p_ang));

	tilt_filt u_filt (
		.clk, .arst_n, .start(state_q == T_LANE && (lr_done_q || r_done) &&
			(lp_done_q || p_done) && !(r_done || p_done)),
		.weight(weight_q), .roll_in(r_ang), .pitch_in(p_ang),
		.done(f_done), .roll_acc(r_acc), .pitch_acc(p_acc));

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) weight_q <= WeightReset;
		else if (filter_weight_we) weight_q <= filter_weight_wdata;
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= T_IDLE;
			lr_done_q    <= 1'b0;
			lp_done_q    <= 1'b0;
			out_ch.valid <= 1'b0;
		end else begin
			if (out_load) out_ch.valid <= 1'b1;
			else if (out_ch.ready) out_ch.valid <= 1'b0;
			unique case (state_q)
				T_IDLE: if (ctl.start) begin
					lr_done_q <= 1'b0;
					lp_done_q <= 1'b0;
					state_q   <= T_LANE;
				end
				T_LANE: begin
					if (r_done) lr_done_q <= 1'b1;
					if (p_done) lp_done_q <= 1'b1;
					if (lr_done_q && lp_done_q) state_q <= T_FILT;
				end
				T_FILT: if (f_done) state_q <= T_OUT;
				default: if (out_load) begin
					out_ch.roll_angle     <= r_ang;
					out_ch.pitch_angle    <= p_ang;
					out_ch.roll_smoothed  <= r_acc;
					out_ch.pitch_smoothed <= p_acc;
					state_q               <= T_IDLE;
				end
			endcase
		end
	end
endmodule

// ----- design/tilt_chk.sv -----
// ----------------------------------------------------------------------------
// tilt_chk: port-level checks for the tilt angle block
// Range of the roll angle and the smoothed pitch, and basic channel behavior.
// ----------------------------------------------------------------------------
module tilt_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [14:0] roll_angle,
	input logic signed [14:0] pitch_smoothed
);
	a_roll_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (roll_angle <= 15'sd11520 && roll_angle >= -15'sd11520))
		else $error("roll out of range");
	a_smooth_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch_smoothed <= 15'sd11520 && pitch_smoothed >= -15'sd11520))
		else $error("smoothed pitch out of range");
	a_no_immediate: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid || $past(out_valid))
		else $error("result appeared right after accept");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(roll_angle))
		else $error("stalled word changed");
endmodule

bind accel_tilt_angles_filtered tilt_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.roll_angle(out_ch.roll_angle), .pitch_smoothed(out_ch.pitch_smoothed));
